/* rtl/core/rsadsm_pkg.sv */
// Package: payload types, status codes and sizing constants for the small-modulus RSA decryptor.
package rsadsm_pkg;

    localparam int unsigned FIELD_W = 17;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_NO_DIVISOR     = 2'd1,
        ST_NOT_INVERTIBLE = 2'd2
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] public_exponent;
        logic [FIELD_W-1:0] modulus;
        logic [FIELD_W-1:0] ciphertext;
    } in_beat_t;

    typedef struct packed {
        logic [FIELD_W-1:0] plaintext;
        status_t            status;
    } out_beat_t;

    // Requests and results between the sequencer and the bit-serial divider.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/rsa_decrypt_small_modulus_unit.sv */
// Top level: factor n, invert e mod phi, then c^d mod n, over one serial divider.
//
//  channel | ports               | direction | payload
//  input   | s_valid/s_ready/s_* | in        | in_beat_t (e, n, c)
//  result  | m_valid/m_ready/m_* | out       | out_beat_t (plaintext, status)
//
// One item at a time. Every divide runs on the shared bit-serial divider
// (start, one step per bit, done); an item costs about (trial divisors +
// Euclid steps + up to 2 per exponent bit + 2) divides.
// Reset clears the sequencer and output valid; no clearing pass.
// A waiting result blocks only the next item's start, held in the output register.
module rsa_decrypt_small_modulus_unit #(
    parameter int unsigned DIVISOR_LIMIT = 300
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rsadsm_pkg::in_beat_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsadsm_pkg::out_beat_t m_data
);

    localparam int unsigned NW = rsadsm_pkg::FIELD_W;
    localparam int unsigned DW = 2 * NW;
    localparam int unsigned LW = $clog2(DIVISOR_LIMIT + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_TRIAL = 10'b0000000010,
        S_QDIV  = 10'b0000000100,
        S_EUC   = 10'b0000001000,
        S_FIXD  = 10'b0000010000,
        S_CRED  = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_SQR   = 10'b0010000000,
        S_WAIT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [NW-1:0] e_reg, e_next, n_reg, n_next, c_reg, c_next;
    logic [LW-1:0] i_reg, i_next;
    logic [NW-1:0] phi_reg, phi_next;
    // Euclid: a, b nonnegative; t values signed
    logic [NW-1:0] a_reg, a_next, b_reg, b_next;
    logic signed [NW+1:0] ta_reg, ta_next, tb_reg, tb_next;
    logic [NW-1:0] d_reg, d_next, acc_reg, acc_next, sq_reg, sq_next;
    logic          mulsel_reg, mulsel_next;
    logic          sqsel_reg, sqsel_next;
    logic          wait_reg, wait_next;
    rsadsm_pkg::out_beat_t res_reg, res_next;
    logic          mv_reg, mv_next;

    rsadsm_pkg::div_ctrl_t dctl;
    rsadsm_pkg::div_stat_t dst;
    logic [DW-1:0] dvd, dvs, quo, rem;
    logic [NW-1:0] rem_n;
    logic signed [NW+1:0] tnew;
    logic [DW-1:0] prod;

    rsadsm_divider #(.W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctrl(dctl), .dividend(dvd),
        .divisor(dvs), .stat(dst), .quotient(quo), .remainder(rem)
    );

    assign rem_n = rem[NW-1:0];
    // quotient of a by b fits in NW bits; product narrowed to t width
    assign tnew  = ta_reg - (NW+2)'($signed({1'b0, quo[NW-1:0]}) * tb_reg);

    always_comb begin
        state_next  = state_reg;
        e_next = e_reg; n_next = n_reg; c_next = c_reg;
        i_next = i_reg; phi_next = phi_reg;
        a_next = a_reg; b_next = b_reg; ta_next = ta_reg; tb_next = tb_reg;
        d_next = d_reg; acc_next = acc_reg; sq_next = sq_reg;
        mulsel_next = mulsel_reg; sqsel_next = sqsel_reg;
        wait_next = 1'b0;
        res_next = res_reg; mv_next = mv_reg;
        dctl.start = 1'b0;
        dvd = '0; dvs = '0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && !mv_reg) begin
                    e_next = s_data.public_exponent;
                    n_next = s_data.modulus;
                    c_next = s_data.ciphertext;
                    i_next = LW'(2);
                    state_next = S_TRIAL;
                end
            end
            S_TRIAL: begin
                if (!wait_reg && !dst.busy && !dst.done) begin
                    if (i_reg >= LW'(DIVISOR_LIMIT) || {{(NW+1){1'b0}}, i_reg} >=
                        (NW+LW+1)'(n_reg)) begin
                        res_next.plaintext = '0;
                        res_next.status = rsadsm_pkg::ST_NO_DIVISOR;
                        state_next = S_OUT;
                    end else begin
                        dctl.start = 1'b1;
                        dvd = DW'(n_reg);
                        dvs = DW'(i_reg);
                        wait_next = 1'b1;
                    end
                end else if (dst.done) begin
                    if (rem == '0) begin
                        phi_next = n_reg - NW'(i_reg) - quo[NW-1:0] + NW'(1);
                        a_next = n_reg - NW'(i_reg) - quo[NW-1:0] + NW'(1);
                        b_next = e_reg;
                        ta_next = '0;
                        tb_next = (NW+2)'(1);
                        state_next = S_EUC;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            S_EUC: begin
                if (!wait_reg && !dst.busy && !dst.done) begin
                    if (b_reg == '0) begin
                        state_next = S_FIXD;
                    end else begin
                        dctl.start = 1'b1;
                        dvd = DW'(a_reg);
                        dvs = DW'(b_reg);
                        wait_next = 1'b1;
                    end
                end else if (dst.done) begin
                    a_next = b_reg;
                    b_next = rem_n;
                    ta_next = tb_reg;
                    tb_next = tnew;
                end
            end
            S_FIXD: begin
                if (a_reg != NW'(1)) begin
                    res_next.plaintext = '0;
                    res_next.status = rsadsm_pkg::ST_NOT_INVERTIBLE;
                    state_next = S_OUT;
                end else begin
                    // |ta| < phi, so one add brings it into range; phi==1 gives 0
                    if (ta_reg < 0) d_next = NW'(ta_reg + $signed({2'b00, phi_reg}));
                    else d_next = NW'(ta_reg);
                    if (phi_reg == NW'(1)) d_next = '0;
                    state_next = S_CRED;
                end
            end
            S_CRED: begin
                // sq = c mod n, then acc = 1 mod n
                if (!wait_reg && !dst.busy && !dst.done) begin
                    dctl.start = 1'b1;
                    dvd = sqsel_reg ? DW'(1) : DW'(c_reg);
                    dvs = DW'(n_reg);
                    wait_next = 1'b1;
                end else if (dst.done) begin
                    if (!sqsel_reg) begin
                        sq_next = rem_n;
                        sqsel_next = 1'b1;
                    end else begin
                        acc_next = rem_n;
                        sqsel_next = 1'b0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (d_reg == '0) begin
                    res_next.plaintext = acc_reg;
                    res_next.status = rsadsm_pkg::ST_OK;
                    state_next = S_OUT;
                end else if (!d_reg[0]) begin
                    state_next = S_SQR;
                end else if (!wait_reg && !dst.busy && !mulsel_reg) begin
                    dctl.start = 1'b1;
                    dvd = prod;
                    dvs = DW'(n_reg);
                    wait_next = 1'b1;
                    mulsel_next = 1'b1;
                end else if (dst.done) begin
                    acc_next = rem_n;
                    mulsel_next = 1'b0;
                    state_next = S_SQR;
                end
            end
            S_SQR: begin
                if (!wait_reg && !dst.busy && !mulsel_reg) begin
                    dctl.start = 1'b1;
                    dvd = prod;
                    dvs = DW'(n_reg);
                    wait_next = 1'b1;
                    mulsel_next = 1'b1;
                end else if (dst.done) begin
                    sq_next = rem_n;
                    d_next = d_reg >> 1;
                    mulsel_next = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_OUT: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_QDIV, S_WAIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // one 17x17 multiply feeds the divider; operands chosen by state
    assign prod = DW'(((state_reg == S_SQR) ? sq_reg : acc_reg)) * DW'(sq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mv_reg     <= 1'b0;
            wait_reg   <= 1'b0;
            mulsel_reg <= 1'b0;
            sqsel_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mv_reg     <= mv_next;
            wait_reg   <= wait_next;
            mulsel_reg <= mulsel_next;
            sqsel_reg  <= sqsel_next;
        end
        e_reg <= e_next; n_reg <= n_next; c_reg <= c_next;
        i_reg <= i_next; phi_reg <= phi_next;
        a_reg <= a_next; b_reg <= b_next; ta_reg <= ta_next; tb_reg <= tb_next;
        d_reg <= d_next; acc_reg <= acc_next; sq_reg <= sq_next;
        res_reg <= res_next;
    end

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_data  = res_reg;

endmodule

/* rtl/core/rsadsm_divider.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
module rsadsm_divider #(
    parameter int unsigned W = 34
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rsadsm_pkg::div_ctrl_t ctrl,
    input  logic [W-1:0]        dividend,
    input  logic [W-1:0]        divisor,
    output rsadsm_pkg::div_stat_t stat,
    output logic [W-1:0]        quotient,
    output logic [W-1:0]        remainder
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (ctrl.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/rsadsm_checker.sv */
// Port-level checker for the decryptor, bound to the top level.
module rsadsm_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input rsadsm_pkg::out_beat_t m_data
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= rsadsm_pkg::ST_NOT_INVERTIBLE)
        else $error("undefined status");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != rsadsm_pkg::ST_OK |-> m_data.plaintext == '0)
        else $error("failed item carries nonzero plaintext");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat accepted while item in flight");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind rsa_decrypt_small_modulus_unit rsadsm_checker u_rsadsm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
